/* rtl/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
// Plain text macros only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with asynchronous active-low reset disable.
`define FFA_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Same, on the house clock and reset names.
`define FFA_ASSERT_CR(lbl, prop, msg) \
    `FFA_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

/* rtl/ffa_pkg.sv */
// Shared types and constants for the first-fit chunk allocator.
// No dependencies.
package ffa_pkg;

    localparam int HEAP_BYTES_DEFAULT  = 65536;
    localparam int CHUNK_SLOTS_DEFAULT = 16;

    localparam int MODE_W   = 1;
    localparam int SIZE_W   = 17;
    localparam int OFF_W    = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_SHIFT  = 2'd1,
        OP_LOAD   = 2'd2,
        OP_INSERT = 2'd3
    } chain_op_t;

    // Command broadcast to every cell of a chain.
    typedef struct packed {
        chain_op_t op;
        logic      ld;   // on shift: the cell at idx takes din
    } chain_ctl_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_USED_FULL = 2'd1,
        ST_NO_FIT    = 2'd2,
        ST_UNKNOWN   = 2'd3
    } status_t;

endpackage

/* rtl/ffa_if.sv */
// Request and response channel interfaces of the allocator.
// Depends on ffa_pkg for field widths.
interface ffa_req_if;
    import ffa_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SIZE_W-1:0] request_size;
    logic [OFF_W-1:0]  chunk_offset;

    modport source (output valid, mode, request_size, chunk_offset, input ready);
    modport sink   (input valid, mode, request_size, chunk_offset, output ready);
endinterface

interface ffa_rsp_if;
    import ffa_pkg::*;
    logic                valid;
    logic                ready;
    logic [OFF_W-1:0]    granted_offset;
    logic [STATUS_W-1:0] status;

    modport source (output valid, granted_offset, status, input ready);
    modport sink   (input valid, granted_offset, status, output ready);
endinterface

/* rtl/ffa_cell.sv */
// One cell of a chunk chain: holds {start, length}, shifts, loads, sorted insert.
// Depends on ffa_pkg.
module ffa_cell #(
    parameter int          DW      = 37,
    parameter int          KW      = 16,
    parameter int          CW      = 5,
    parameter int          K       = 0,
    parameter logic [DW-1:0] RST_VAL = '0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ffa_pkg::chain_ctl_t ctl,
    input  logic [CW-1:0]      idx,
    input  logic [CW-1:0]      cnt,
    input  logic [DW-1:0]      din,
    input  logic [DW-1:0]      up,
    input  logic [DW-1:0]      dn,
    input  logic               dn_gt,
    output logic [DW-1:0]      q,
    output logic               gt
);
    import ffa_pkg::*;

    logic [DW-1:0] q_reg;
    logic [DW-1:0] q_next;
    logic          hit;
    logic          valid;

    assign hit   = (idx == CW'(K));
    assign valid = (CW'(K) < cnt);
    assign gt    = valid && (q_reg[DW-1 -: KW] > din[DW-1 -: KW]);
    assign q     = q_reg;

    always_comb
    begin
        unique case (ctl.op)
            OP_HOLD:   q_next = q_reg;
            OP_SHIFT:  q_next = (hit && ctl.ld) ? din : up;
            OP_LOAD:   q_next = hit ? din : q_reg;
            OP_INSERT:
            begin
                if (dn_gt)
                    q_next = dn;
                else if (gt || cnt == CW'(K))
                    q_next = din;
                else
                    q_next = q_reg;
            end
            default:   q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg <= RST_VAL;
        else
            q_reg <= q_next;
    end

endmodule

/* rtl/ffa_chain.sv */
// Row of ffa_cell instances; cell 0 is the head seen by the controller.
// Depends on ffa_pkg and ffa_cell.
module ffa_chain #(
    parameter int            N   = 16,
    parameter int            DW  = 37,
    parameter int            KW  = 16,
    parameter int            CW  = 5,
    parameter logic [DW-1:0] RST0 = '0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ffa_pkg::chain_ctl_t ctl,
    input  logic [CW-1:0]       idx,
    input  logic [CW-1:0]       cnt,
    input  logic [DW-1:0]       din,
    output logic [DW-1:0]       head
);
    import ffa_pkg::*;

    logic [DW-1:0] q  [N];
    logic          gt [N];

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        logic [DW-1:0] up_w;
        logic [DW-1:0] dn_w;
        logic          dn_gt_w;

        if (k == N - 1)
        begin : g_top
            assign up_w = '0;
        end
        else
        begin : g_mid
            assign up_w = q[k+1];
        end

        if (k == 0)
        begin : g_head
            assign dn_w    = '0;
            assign dn_gt_w = 1'b0;
        end
        else
        begin : g_body
            assign dn_w    = q[k-1];
            assign dn_gt_w = gt[k-1];
        end

        ffa_cell #(
            .DW      (DW),
            .KW      (KW),
            .CW      (CW),
            .K       (k),
            .RST_VAL ((k == 0) ? RST0 : '0)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .idx   (idx),
            .cnt   (cnt),
            .din   (din),
            .up    (up_w),
            .dn    (dn_w),
            .dn_gt (dn_gt_w),
            .q     (q[k]),
            .gt    (gt[k])
        );
    end

    assign head = q[0];

endmodule

/* rtl/first_fit_chunk_allocator.sv */
// First-fit chunk allocator: one request transfer in, one response transfer out.
// An allocate scans the free table and takes the first fit; a free finds the chunk in
// the used table, then sorts the free table with it and merges adjacent chunks.
// The work is done by the cell chains: every table entry passes the chain head once
// per scan, the free table is drained one entry a cycle into a sorting chain, and the
// merge pops that chain one chunk a cycle. Rejected requests (used table full, zero
// size, empty table) skip the scans. One request is in work at a time; a finished
// response waits in an output register, so a new request transfer is accepted while
// the previous response is still held. After reset the heap is one free chunk.
// Depends on ffa_pkg, ffa_if, ffa_chain, ffa_cell and assert_macros.svh.
`include "assert_macros.svh"

module first_fit_chunk_allocator #(
    parameter int HEAP_BYTES  = ffa_pkg::HEAP_BYTES_DEFAULT,
    parameter int CHUNK_SLOTS = ffa_pkg::CHUNK_SLOTS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    ffa_req_if.sink   req,
    ffa_rsp_if.source rsp
);
    import ffa_pkg::*;

    // Offset, length, entry and count widths.
    localparam int OW = $clog2(HEAP_BYTES);
    localparam int LW = $clog2(HEAP_BYTES + 1);
    localparam int DW = OW + LW;
    localparam int SW = (LW > SIZE_W) ? LW : SIZE_W;
    localparam int MW = (OW > OFF_W) ? OW : OFF_W;
    localparam int CW = $clog2(CHUNK_SLOTS + 2);
    localparam logic [DW-1:0] FREE_RST = DW'(HEAP_BYTES);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_ASCAN  = 9'b000000010,  // rotate free table, take first fit
        S_AAPP   = 9'b000000100,  // record used chunk, append remainder
        S_UFIND  = 9'b000001000,  // rotate used table, take matching chunk
        S_DRAIN  = 9'b000010000,  // free table -> sorting chain
        S_INSNEW = 9'b000100000,  // freed chunk -> sorting chain
        S_MERGE  = 9'b001000000,  // sorting chain -> free table, coalescing
        S_MFLUSH = 9'b010000000,  // write last coalesced chunk
        S_DONE   = 9'b100000000   // hand result to output register
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] free_cnt_reg, free_cnt_next;
    logic [CW-1:0] used_cnt_reg, used_cnt_next;
    logic [CW-1:0] sort_cnt_reg, sort_cnt_next;
    logic [CW-1:0] step_reg, step_next;
    logic          found_reg, found_next;
    logic          acc_v_reg, acc_v_next;
    logic          out_valid_reg, out_valid_next;

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [OW-1:0]     hit_start_reg, hit_start_next;
    logic [LW-1:0]     hit_len_reg, hit_len_next;
    logic [OW-1:0]     acc_start_reg, acc_start_next;
    logic [LW-1:0]     acc_len_reg, acc_len_next;
    status_t           res_status_reg, res_status_next;
    logic [OFF_W-1:0]  res_granted_reg, res_granted_next;
    status_t           out_status_reg, out_status_next;
    logic [OFF_W-1:0]  out_granted_reg, out_granted_next;

    // Chain command buses.
    chain_ctl_t    free_ctl, used_ctl, sort_ctl;
    logic [CW-1:0] free_idx, used_idx;
    logic [DW-1:0] free_din, used_din, sort_din;
    logic [DW-1:0] free_head, used_head, sort_head;

    ffa_chain #(
        .N (CHUNK_SLOTS), .DW (DW), .KW (OW), .CW (CW), .RST0 (FREE_RST)
    ) u_free (
        .clk (clk), .rst_n (rst_n), .ctl (free_ctl), .idx (free_idx),
        .cnt (free_cnt_reg), .din (free_din), .head (free_head)
    );

    ffa_chain #(
        .N (CHUNK_SLOTS), .DW (DW), .KW (OW), .CW (CW), .RST0 ('0)
    ) u_used (
        .clk (clk), .rst_n (rst_n), .ctl (used_ctl), .idx (used_idx),
        .cnt (used_cnt_reg), .din (used_din), .head (used_head)
    );

    // Sorting chain holds the whole free table plus the freed chunk.
    ffa_chain #(
        .N (CHUNK_SLOTS + 1), .DW (DW), .KW (OW), .CW (CW), .RST0 ('0)
    ) u_sort (
        .clk (clk), .rst_n (rst_n), .ctl (sort_ctl), .idx ('0),
        .cnt (sort_cnt_reg), .din (sort_din), .head (sort_head)
    );

    // Head fields and datapath.
    logic [OW-1:0] fh_start, uh_start, sh_start;
    logic [LW-1:0] fh_len, uh_len, sh_len;
    logic [SW-1:0] size_sw;
    logic [LW-1:0] size_lw;
    logic          fit, match, touch;
    logic [SW:0]   rem_sum;
    logic [LW:0]   acc_end;
    logic [MW-1:0] hit_start_mw;

    assign fh_start = free_head[DW-1 -: OW];
    assign fh_len   = free_head[LW-1:0];
    assign uh_start = used_head[DW-1 -: OW];
    assign uh_len   = used_head[LW-1:0];
    assign sh_start = sort_head[DW-1 -: OW];
    assign sh_len   = sort_head[LW-1:0];

    assign size_sw      = SW'(size_reg);
    assign size_lw      = size_sw[LW-1:0];
    assign fit          = (SW'(fh_len) >= size_sw);
    assign match        = (MW'(uh_start) == MW'(off_reg));
    assign rem_sum      = (SW+1)'(hit_start_reg) + (SW+1)'(size_reg);
    assign acc_end      = (LW+1)'(acc_start_reg) + (LW+1)'(acc_len_reg);
    assign touch        = acc_v_reg && (acc_end == (LW+1)'(sh_start));
    assign hit_start_mw = MW'(hit_start_reg);

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.granted_offset = out_granted_reg;

    always_comb
    begin
        state_next       = state_reg;
        free_cnt_next    = free_cnt_reg;
        used_cnt_next    = used_cnt_reg;
        sort_cnt_next    = sort_cnt_reg;
        step_next        = step_reg;
        found_next       = found_reg;
        acc_v_next       = acc_v_reg;
        size_next        = size_reg;
        off_next         = off_reg;
        hit_start_next   = hit_start_reg;
        hit_len_next     = hit_len_reg;
        acc_start_next   = acc_start_reg;
        acc_len_next     = acc_len_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        out_status_next  = out_status_reg;
        out_granted_next = out_granted_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;

        free_ctl = '{op: OP_HOLD, ld: 1'b0};
        used_ctl = '{op: OP_HOLD, ld: 1'b0};
        sort_ctl = '{op: OP_HOLD, ld: 1'b0};
        free_idx = '0;
        used_idx = '0;
        free_din = '0;
        used_din = '0;
        sort_din = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    size_next        = req.request_size;
                    off_next         = req.chunk_offset;
                    found_next       = 1'b0;
                    res_granted_next = '0;
                    state_next       = S_DONE;
                    if (req.mode == MODE_W'(0))
                    begin
                        priority if (used_cnt_reg >= CW'(CHUNK_SLOTS))
                            res_status_next = ST_USED_FULL;
                        else if (req.request_size == '0 || free_cnt_reg == '0)
                            res_status_next = ST_NO_FIT;
                        else
                        begin
                            step_next  = free_cnt_reg;
                            state_next = S_ASCAN;
                        end
                    end
                    else
                    begin
                        if (used_cnt_reg == '0)
                            res_status_next = ST_UNKNOWN;
                        else
                        begin
                            step_next  = used_cnt_reg;
                            state_next = S_UFIND;
                        end
                    end
                end
            end

            S_ASCAN:
            begin
                // Each entry passes the head once; the first fit leaves the ring.
                if (!found_reg && fit)
                begin
                    free_ctl       = '{op: OP_SHIFT, ld: 1'b0};
                    free_cnt_next  = free_cnt_reg - 1'b1;
                    found_next     = 1'b1;
                    hit_start_next = fh_start;
                    hit_len_next   = fh_len;
                end
                else
                begin
                    free_ctl = '{op: OP_SHIFT, ld: 1'b1};
                    free_idx = free_cnt_reg - 1'b1;
                    free_din = free_head;
                end
                step_next = step_reg - 1'b1;
                if (step_reg == CW'(1))
                begin
                    if (found_reg || fit)
                        state_next = S_AAPP;
                    else
                    begin
                        res_status_next = ST_NO_FIT;
                        state_next      = S_DONE;
                    end
                end
            end

            S_AAPP:
            begin
                used_ctl      = '{op: OP_LOAD, ld: 1'b0};
                used_idx      = used_cnt_reg;
                used_din      = {hit_start_reg, size_lw};
                used_cnt_next = used_cnt_reg + 1'b1;
                if (SW'(hit_len_reg) != size_sw)
                begin
                    free_ctl      = '{op: OP_LOAD, ld: 1'b0};
                    free_idx      = free_cnt_reg;
                    free_din      = {rem_sum[OW-1:0], LW'(hit_len_reg - size_lw)};
                    free_cnt_next = free_cnt_reg + 1'b1;
                end
                res_status_next  = ST_OK;
                res_granted_next = hit_start_mw[OFF_W-1:0];
                state_next       = S_DONE;
            end

            S_UFIND:
            begin
                if (!found_reg && match)
                begin
                    used_ctl       = '{op: OP_SHIFT, ld: 1'b0};
                    used_cnt_next  = used_cnt_reg - 1'b1;
                    found_next     = 1'b1;
                    hit_start_next = uh_start;
                    hit_len_next   = uh_len;
                end
                else
                begin
                    used_ctl = '{op: OP_SHIFT, ld: 1'b1};
                    used_idx = used_cnt_reg - 1'b1;
                    used_din = used_head;
                end
                step_next = step_reg - 1'b1;
                if (step_reg == CW'(1))
                begin
                    if (found_reg || match)
                        state_next = (free_cnt_reg == '0) ? S_INSNEW : S_DRAIN;
                    else
                    begin
                        res_status_next = ST_UNKNOWN;
                        state_next      = S_DONE;
                    end
                end
            end

            S_DRAIN:
            begin
                free_ctl      = '{op: OP_SHIFT, ld: 1'b0};
                free_cnt_next = free_cnt_reg - 1'b1;
                sort_ctl      = '{op: OP_INSERT, ld: 1'b0};
                sort_din      = free_head;
                sort_cnt_next = sort_cnt_reg + 1'b1;
                if (free_cnt_reg == CW'(1))
                    state_next = S_INSNEW;
            end

            S_INSNEW:
            begin
                sort_ctl      = '{op: OP_INSERT, ld: 1'b0};
                sort_din      = {hit_start_reg, hit_len_reg};
                sort_cnt_next = sort_cnt_reg + 1'b1;
                acc_v_next    = 1'b0;
                state_next    = S_MERGE;
            end

            S_MERGE:
            begin
                // acc holds the last free entry until the next chunk settles it.
                sort_ctl      = '{op: OP_SHIFT, ld: 1'b0};
                sort_cnt_next = sort_cnt_reg - 1'b1;
                if (touch)
                    acc_len_next = LW'(acc_len_reg + sh_len);
                else if (free_cnt_reg < CW'(CHUNK_SLOTS))
                begin
                    if (acc_v_reg)
                    begin
                        free_ctl = '{op: OP_LOAD, ld: 1'b0};
                        free_idx = free_cnt_reg - 1'b1;
                        free_din = {acc_start_reg, acc_len_reg};
                    end
                    acc_start_next = sh_start;
                    acc_len_next   = sh_len;
                    acc_v_next     = 1'b1;
                    free_cnt_next  = free_cnt_reg + 1'b1;
                end
                if (sort_cnt_reg == CW'(1))
                    state_next = S_MFLUSH;
            end

            S_MFLUSH:
            begin
                free_ctl        = '{op: OP_LOAD, ld: 1'b0};
                free_idx        = free_cnt_reg - 1'b1;
                free_din        = {acc_start_reg, acc_len_reg};
                res_status_next = ST_OK;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_granted_next = res_granted_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_cnt_reg  <= CW'(1);
            used_cnt_reg  <= '0;
            sort_cnt_reg  <= '0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            acc_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_cnt_reg  <= free_cnt_next;
            used_cnt_reg  <= used_cnt_next;
            sort_cnt_reg  <= sort_cnt_next;
            step_reg      <= step_next;
            found_reg     <= found_next;
            acc_v_reg     <= acc_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg        <= size_next;
        off_reg         <= off_next;
        hit_start_reg   <= hit_start_next;
        hit_len_reg     <= hit_len_next;
        acc_start_reg   <= acc_start_next;
        acc_len_reg     <= acc_len_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        out_status_reg  <= out_status_next;
        out_granted_reg <= out_granted_next;
    end

    `FFA_ASSERT_CR(a_free_cnt_bound, free_cnt_reg <= CW'(CHUNK_SLOTS), "free table overflow")
    `FFA_ASSERT_CR(a_used_cnt_bound, used_cnt_reg <= CW'(CHUNK_SLOTS), "used table overflow")
    `FFA_ASSERT_CR(a_sort_empty_idle, state_reg == S_IDLE |-> sort_cnt_reg == '0, "sort chain not empty")
    `FFA_ASSERT_CR(a_accept_leaves_idle, req.valid && req.ready |=> state_reg != S_IDLE, "request transfer lost")

endmodule
